// ----- hdl/tfp_pkg.sv -----
// Shared types and character constants for the telemetry frame parser.
package tfp_pkg;

  // Frame delimiters and digit bounds (ASCII)
  localparam logic [7:0] CharStart = 8'h3C;  // '<'
  localparam logic [7:0] CharSep   = 8'h2C;  // ','
  localparam logic [7:0] CharEnd   = 8'h3E;  // '>'
  localparam logic [7:0] CharSpace = 8'h20;  // ' '
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'

  // Frame layout, by kept-character position ('<' is position 0)
  localparam logic [4:0] PosFirst    = 5'd1;
  localparam logic [4:0] PosSepA     = 5'd2;
  localparam logic [4:0] PosChargeLo = 5'd3;
  localparam logic [4:0] PosChargeHi = 5'd4;
  localparam logic [4:0] PosSepB     = 5'd5;
  localparam logic [4:0] PosMinLo    = 5'd6;
  localparam logic [4:0] PosMinHi    = 5'd8;
  localparam logic [4:0] PosSepC     = 5'd9;
  localparam logic [4:0] PosRpmLo    = 5'd10;
  localparam logic [4:0] FrameLast   = 5'd15;

  // One decoded frame
  typedef struct packed {
    logic        frame_valid;
    logic [6:0]  charge_percent;
    logic [9:0]  remaining_minutes;
    logic [16:0] rotor_rpm;
  } tfp_result_t;

endpackage

// ----- hdl/tfp_parse.sv -----
// Frame parser: position tracking, field checks and decimal accumulation.
module tfp_parse
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,      // commit the current character
  input  logic [7:0]  rx_char,
  output logic        emit,      // current character completes a frame
  output tfp_result_t result
);

  logic        in_frame_r, in_frame_nxt;
  logic [4:0]  char_position_r, char_position_nxt;
  logic        frame_ok_r, frame_ok_nxt;
  logic [6:0]  charge_accum_r, charge_accum_nxt;
  logic [9:0]  minutes_accum_r, minutes_accum_nxt;
  logic [16:0] rpm_accum_r, rpm_accum_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic        ok_chk;
  logic [6:0]  charge_x10;
  logic [9:0]  minutes_x10;
  logic [16:0] rpm_x10;

  assign is_digit = (rx_char >= CharZero) && (rx_char <= CharNine);
  assign digit    = 4'(rx_char - CharZero);

  // times ten as shift-and-add, wrapping at field width
  assign charge_x10  = (charge_accum_r << 3) + (charge_accum_r << 1);
  assign minutes_x10 = (minutes_accum_r << 3) + (minutes_accum_r << 1);
  assign rpm_x10     = (rpm_accum_r << 3) + (rpm_accum_r << 1);

  // per-character update
  always_comb begin
    in_frame_nxt      = in_frame_r;
    char_position_nxt = char_position_r;
    frame_ok_nxt      = frame_ok_r;
    charge_accum_nxt  = charge_accum_r;
    minutes_accum_nxt = minutes_accum_r;
    rpm_accum_nxt     = rpm_accum_r;
    ok_chk            = frame_ok_r;
    emit              = 1'b0;

    priority if (rx_char == CharStart) begin
      in_frame_nxt      = 1'b1;
      char_position_nxt = PosFirst;
      frame_ok_nxt      = 1'b1;
      charge_accum_nxt  = '0;
      minutes_accum_nxt = '0;
      rpm_accum_nxt     = '0;
    end else if (in_frame_r && (rx_char != CharSpace)) begin
      priority if ((char_position_r == PosSepA) || (char_position_r == PosSepB) ||
                   (char_position_r == PosSepC)) begin
        if (rx_char != CharSep) ok_chk = 1'b0;
      end else if (char_position_r >= FrameLast) begin
        if (rx_char != CharEnd) ok_chk = 1'b0;
      end else if (char_position_r == '0) begin
        ok_chk = 1'b0;
      end else if (!is_digit) begin
        ok_chk = 1'b0;
      end else begin
        priority if ((char_position_r == PosChargeLo) ||
                     (char_position_r == PosChargeHi)) begin
          charge_accum_nxt = charge_x10 + 7'(digit);
        end else if ((char_position_r >= PosMinLo) &&
                     (char_position_r <= PosMinHi)) begin
          minutes_accum_nxt = minutes_x10 + 10'(digit);
        end else if (char_position_r >= PosRpmLo) begin
          rpm_accum_nxt = rpm_x10 + 17'(digit);
        end else begin
          // leading digit: checked only
        end
      end
      frame_ok_nxt = ok_chk;

      if (char_position_r < FrameLast) begin
        char_position_nxt = char_position_r + 5'd1;
      end else begin
        emit              = 1'b1;
        in_frame_nxt      = 1'b0;
        char_position_nxt = '0;
        frame_ok_nxt      = 1'b1;
        charge_accum_nxt  = '0;
        minutes_accum_nxt = '0;
        rpm_accum_nxt     = '0;
      end
    end else begin
      // outside a frame or a space: nothing changes
    end
  end

  // decoded result, zeroed on reject
  always_comb begin
    result.frame_valid       = ok_chk;
    result.charge_percent    = ok_chk ? charge_accum_r  : '0;
    result.remaining_minutes = ok_chk ? minutes_accum_r : '0;
    result.rotor_rpm         = ok_chk ? rpm_accum_r     : '0;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      char_position_r <= '0;
      frame_ok_r      <= 1'b1;
      charge_accum_r  <= '0;
      minutes_accum_r <= '0;
      rpm_accum_r     <= '0;
    end else if (step) begin
      in_frame_r      <= in_frame_nxt;
      char_position_r <= char_position_nxt;
      frame_ok_r      <= frame_ok_nxt;
      charge_accum_r  <= charge_accum_nxt;
      minutes_accum_r <= minutes_accum_nxt;
      rpm_accum_r     <= rpm_accum_nxt;
    end
  end

  // a completed frame returns the parser to hunting
  a_emit_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit |=> !in_frame_r && (char_position_r == '0))
    else $error("parser still in frame after completing one");

  // position never runs past the end marker
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    char_position_r <= FrameLast)
    else $error("char position out of range");

  // hunting implies position zero
  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (char_position_r == '0))
    else $error("position nonzero while hunting");

  // emission only from the last position
  a_emit_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> in_frame_r && (char_position_r == FrameLast))
    else $error("result emitted before end of frame");

endmodule

// ----- hdl/tfp_out_reg.sv -----
// Output register holding one decoded frame until the consumer takes it.
module tfp_out_reg
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  tfp_result_t load_data,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output tfp_result_t out_data
);

  logic        valid_r;
  tfp_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  // a rejected frame carries all-zero numbers
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.frame_valid |->
      (data_r.charge_percent == '0) && (data_r.remaining_minutes == '0) &&
      (data_r.rotor_rpm == '0))
    else $error("rejected frame with nonzero fields");

  // loads only when there is room
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result register overwritten before transfer");

  // a valid flag is raised only by a load
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(load))
    else $error("result valid without load");

endmodule

// ----- hdl/telemetry_frame_parser_core.sv -----
// Top level of the telemetry frame parser: input register, parser, result register.
//
// Accepts one received character per clock and recognizes frames of the form
// <d,dd,ddd,ddddd>. A '<' always restarts a frame, spaces inside a frame are
// skipped and characters outside a frame are dropped. On the closing sixteenth
// character one result transfer is produced: frame_valid and the decoded charge,
// minutes and rpm (all zero on a rejected frame). Sustained throughput is one
// character per cycle, as the parser checks and accumulates each character in
// combinational logic. The closing character is held in the input register, then
// its result is loaded into the result register and offered. in_ready stays high
// while the result register is empty or being drained, so only a stall on the
// result side with a pending frame end holds the input back.
module telemetry_frame_parser_core
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_valid,
  output logic [6:0]  out_charge_percent,
  output logic [9:0]  out_remaining_minutes,
  output logic [16:0] out_rotor_rpm
);

  logic        in_vld_r;
  logic [7:0]  in_char_r;
  logic        emit;
  logic        can_load;
  logic        advance;
  tfp_result_t parse_res;
  tfp_result_t out_data;

  // the held character retires unless it ends a frame and the output is full
  assign advance  = in_vld_r && (!emit || can_load);
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_rx_char;
    end
  end

  tfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_char (in_char_r),
    .emit    (emit),
    .result  (parse_res)
  );

  tfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .load_data (parse_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_frame_valid       = out_data.frame_valid;
  assign out_charge_percent    = out_data.charge_percent;
  assign out_remaining_minutes = out_data.remaining_minutes;
  assign out_rotor_rpm         = out_data.rotor_rpm;

endmodule
